/* hw/rtl/lvpr_pkg.sv */
// Shared types and constants for the longest valley and peak run core.
`timescale 1ns / 1ps

package lvpr_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int LENGTH_BITS = INDEX_BITS + 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_item_type;

   typedef struct packed {
      logic                   valley_found;
      logic [LENGTH_BITS-1:0] valley_length;
      logic [INDEX_BITS-1:0]  valley_first;
      logic [INDEX_BITS-1:0]  valley_final;
      logic                   peak_found;
      logic [LENGTH_BITS-1:0] peak_length;
      logic [INDEX_BITS-1:0]  peak_first;
      logic [INDEX_BITS-1:0]  peak_final;
      logic                   too_long;
   } rsp_item_type;

endpackage

/* hw/rtl/lvpr_tracker.sv */
// Run tracker: sequence state, one sample per step, and the summary it builds.
`timescale 1ns / 1ps

module lvpr_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lvpr_pkg::req_item_type item,
   output lvpr_pkg::rsp_item_type summary
);
   import lvpr_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] previous_sample;
      logic                          have_previous;
      logic [LENGTH_BITS-1:0]        position;
      logic [INDEX_BITS-1:0]         fall_steps;
      logic [INDEX_BITS-1:0]         rise_steps;
      logic [INDEX_BITS-1:0]         valley_begin;
      logic [INDEX_BITS-1:0]         peak_rise_steps;
      logic [INDEX_BITS-1:0]         peak_fall_steps;
      logic [INDEX_BITS-1:0]         peak_begin;
      logic [LENGTH_BITS-1:0]        best_valley_length;
      logic [INDEX_BITS-1:0]         best_valley_first;
      logic [INDEX_BITS-1:0]         best_valley_final;
      logic [LENGTH_BITS-1:0]        best_peak_length;
      logic [INDEX_BITS-1:0]         best_peak_first;
      logic [INDEX_BITS-1:0]         best_peak_final;
      logic                          overflowed;
   } track_state_type;

   track_state_type state_ff;
   track_state_type state_in;
   track_state_type nxt;

   logic [INDEX_BITS-1:0]  idx;
   logic [INDEX_BITS-1:0]  steps_up;
   logic [LENGTH_BITS-1:0] run_len;

   always_comb begin
      nxt      = state_ff;
      idx      = state_ff.position[INDEX_BITS-1:0];
      steps_up = '0;
      run_len  = '0;
      // position has reached the maximum once its top bit is set
      if (state_ff.position[LENGTH_BITS-1]) begin
         nxt.overflowed = 1'b1;
      end else begin
         if (state_ff.have_previous) begin
            if (item.sample < state_ff.previous_sample) begin
               if (state_ff.rise_steps != '0 || state_ff.fall_steps == '0) begin
                  nxt.valley_begin = idx - INDEX_BITS'(1);
                  nxt.fall_steps   = INDEX_BITS'(1);
                  nxt.rise_steps   = '0;
               end else begin
                  nxt.fall_steps = state_ff.fall_steps + INDEX_BITS'(1);
               end
               if (state_ff.peak_rise_steps != '0) begin
                  steps_up            = state_ff.peak_fall_steps + INDEX_BITS'(1);
                  nxt.peak_fall_steps = steps_up;
                  run_len = LENGTH_BITS'(state_ff.peak_rise_steps)
                          + LENGTH_BITS'(steps_up) + LENGTH_BITS'(1);
                  if (run_len > state_ff.best_peak_length) begin
                     nxt.best_peak_length = run_len;
                     nxt.best_peak_first  = state_ff.peak_begin;
                     nxt.best_peak_final  = idx;
                  end
               end
            end else if (item.sample > state_ff.previous_sample) begin
               if (state_ff.peak_fall_steps != '0 || state_ff.peak_rise_steps == '0) begin
                  nxt.peak_begin      = idx - INDEX_BITS'(1);
                  nxt.peak_rise_steps = INDEX_BITS'(1);
                  nxt.peak_fall_steps = '0;
               end else begin
                  nxt.peak_rise_steps = state_ff.peak_rise_steps + INDEX_BITS'(1);
               end
               if (state_ff.fall_steps != '0) begin
                  steps_up       = state_ff.rise_steps + INDEX_BITS'(1);
                  nxt.rise_steps = steps_up;
                  run_len = LENGTH_BITS'(state_ff.fall_steps)
                          + LENGTH_BITS'(steps_up) + LENGTH_BITS'(1);
                  if (run_len > state_ff.best_valley_length) begin
                     nxt.best_valley_length = run_len;
                     nxt.best_valley_first  = state_ff.valley_begin;
                     nxt.best_valley_final  = idx;
                  end
               end
            end else begin
               // equal pair breaks both runs
               nxt.fall_steps      = '0;
               nxt.rise_steps      = '0;
               nxt.peak_rise_steps = '0;
               nxt.peak_fall_steps = '0;
            end
         end
         nxt.previous_sample = item.sample;
         nxt.have_previous   = 1'b1;
         nxt.position        = state_ff.position + LENGTH_BITS'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      if (step) begin
         state_in = item.last ? '0 : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      summary.valley_found  = (nxt.best_valley_length != '0);
      summary.valley_length = nxt.best_valley_length;
      summary.valley_first  = nxt.best_valley_first;
      summary.valley_final  = nxt.best_valley_final;
      summary.peak_found    = (nxt.best_peak_length != '0);
      summary.peak_length   = nxt.best_peak_length;
      summary.peak_first    = nxt.best_peak_first;
      summary.peak_final    = nxt.best_peak_final;
      summary.too_long      = nxt.overflowed;
   end

endmodule

/* hw/rtl/longest_valley_and_peak_run_core.sv */
// Top level: longest valley and longest peak over a stream of signed samples.
// Throughput: one sample item per clock unless stalled; tracker folds one per step.
// Path: a last item crosses the input register; its summary is registered for rsp_.
// Stalls: a last item waits in the input register while rsp_stall holds a result.
// Reset: synchronous, active high; clears both valid flags and all run state.
// After each last item all run state clears for the next sequence.
`timescale 1ns / 1ps

module longest_valley_and_peak_run_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lvpr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lvpr_pkg::rsp_item_type rsp_item
);
   import lvpr_pkg::*;

   // Input register: holds one item until the tracker consumes it.
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;

   // Result register: one summary per sequence.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;

   rsp_item_type summary;
   logic         req_take;
   logic         out_free;
   logic         advance;
   logic         emit;

   // The result register can take a new summary when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Non-last items never wait on the output side.
   assign advance   = in_valid_ff && (!in_item_ff.last || out_free);
   assign emit      = advance && in_item_ff.last;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   lvpr_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .summary (summary)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (emit) begin
         rsp_item_ff <= summary;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A result appears only after a last item left the input register.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result without a last item");

   // A waiting item stays put until the tracker takes it.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input register lost a waiting item");

   // Found flags agree with the kept lengths.
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_item_ff.valley_found == (rsp_item_ff.valley_length != '0))
                     && (rsp_item_ff.peak_found == (rsp_item_ff.peak_length != '0))))
      else $error("found flag and length disagree");

   // A kept peak always ends after it starts.
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.peak_found) |->
         (rsp_item_ff.peak_final > rsp_item_ff.peak_first))
      else $error("peak ends before it starts");

endmodule

/* dv/lvpr_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts the valley and peak summary for each sequence and compares results.

module lvpr_checker #(
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  lvpr_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lvpr_pkg::rsp_item_type rsp_item,
   output int                     failures,
   output int                     pending,
   output int                     checked
);
   import lvpr_pkg::*;

   // running view of the current sequence
   logic signed [SAMPLE_BITS-1:0] prev_sample;
   logic                          have_prev;
   logic [LENGTH_BITS-1:0]        sample_count;
   logic [INDEX_BITS-1:0]         valley_fall, valley_rise, valley_start;
   logic [INDEX_BITS-1:0]         peak_rise, peak_fall, peak_start;
   logic [LENGTH_BITS-1:0]        best_valley_len, best_peak_len;
   logic [INDEX_BITS-1:0]         best_valley_first, best_valley_final;
   logic [INDEX_BITS-1:0]         best_peak_first, best_peak_final;
   logic                          overflow_seen;

   rsp_item_type expected_summaries[$];
   int           fail_count = 0;
   int           summary_count = 0;

   initial begin
      failures = 0;
      pending  = 0;
      checked  = 0;
   end

   task automatic clear_runs();
      prev_sample       = '0;
      have_prev         = 1'b0;
      sample_count      = '0;
      valley_fall       = '0;
      valley_rise       = '0;
      valley_start      = '0;
      peak_rise         = '0;
      peak_fall         = '0;
      peak_start        = '0;
      best_valley_len   = '0;
      best_valley_first = '0;
      best_valley_final = '0;
      best_peak_len     = '0;
      best_peak_first   = '0;
      best_peak_final   = '0;
      overflow_seen     = 1'b0;
   endtask

   task automatic fold_sample(input req_item_type item);
      logic signed [SAMPLE_BITS-1:0] cur;
      logic [INDEX_BITS-1:0]         idx;
      logic [LENGTH_BITS-1:0]        run_len;
      rsp_item_type                  summary;
      cur = item.sample;
      idx = sample_count[INDEX_BITS-1:0];
      if (int'(sample_count) >= MAX_SAMPLES) begin
         overflow_seen = 1'b1;
      end else begin
         if (have_prev) begin
            if (cur < prev_sample) begin
               if (valley_rise != 0 || valley_fall == 0) begin
                  valley_start = idx - 1'b1;
                  valley_fall  = INDEX_BITS'(1);
                  valley_rise  = '0;
               end else begin
                  valley_fall = valley_fall + 1'b1;
               end
               if (peak_rise != 0) begin
                  peak_fall = peak_fall + 1'b1;
                  run_len = LENGTH_BITS'(peak_rise) + LENGTH_BITS'(peak_fall) + 1'b1;
                  if (run_len > best_peak_len) begin
                     best_peak_len   = run_len;
                     best_peak_first = peak_start;
                     best_peak_final = idx;
                  end
               end
            end else if (cur > prev_sample) begin
               if (peak_fall != 0 || peak_rise == 0) begin
                  peak_start = idx - 1'b1;
                  peak_rise  = INDEX_BITS'(1);
                  peak_fall  = '0;
               end else begin
                  peak_rise = peak_rise + 1'b1;
               end
               if (valley_fall != 0) begin
                  valley_rise = valley_rise + 1'b1;
                  run_len = LENGTH_BITS'(valley_fall) + LENGTH_BITS'(valley_rise) + 1'b1;
                  if (run_len > best_valley_len) begin
                     best_valley_len   = run_len;
                     best_valley_first = valley_start;
                     best_valley_final = idx;
                  end
               end
            end else begin
               // equal pair ends every run
               valley_fall = '0;
               valley_rise = '0;
               peak_rise   = '0;
               peak_fall   = '0;
            end
         end
         prev_sample  = cur;
         have_prev    = 1'b1;
         sample_count = sample_count + 1'b1;
      end
      if (item.last) begin
         summary.valley_found  = (best_valley_len != 0);
         summary.valley_length = best_valley_len;
         summary.valley_first  = best_valley_first;
         summary.valley_final  = best_valley_final;
         summary.peak_found    = (best_peak_len != 0);
         summary.peak_length   = best_peak_len;
         summary.peak_first    = best_peak_first;
         summary.peak_final    = best_peak_final;
         summary.too_long      = overflow_seen;
         expected_summaries.push_back(summary);
         clear_runs();
      end
   endtask

   task automatic check_field(input string field, input logic [LENGTH_BITS-1:0] want,
                              input logic [LENGTH_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_runs();
         expected_summaries.delete();
      end else begin
         // compare first: a result on this edge belongs to an earlier last item
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $error("result with no sequence waiting for it");
               fail_count++;
            end else begin
               check_field("valley_found", expected_summaries[0].valley_found,
                           rsp_item.valley_found);
               check_field("valley_length", expected_summaries[0].valley_length,
                           rsp_item.valley_length);
               check_field("valley_first", expected_summaries[0].valley_first,
                           rsp_item.valley_first);
               check_field("valley_final", expected_summaries[0].valley_final,
                           rsp_item.valley_final);
               check_field("peak_found", expected_summaries[0].peak_found,
                           rsp_item.peak_found);
               check_field("peak_length", expected_summaries[0].peak_length,
                           rsp_item.peak_length);
               check_field("peak_first", expected_summaries[0].peak_first,
                           rsp_item.peak_first);
               check_field("peak_final", expected_summaries[0].peak_final,
                           rsp_item.peak_final);
               check_field("too_long", expected_summaries[0].too_long, rsp_item.too_long);
               void'(expected_summaries.pop_front());
               summary_count++;
            end
         end
         if (req_valid && !req_stall) begin
            fold_sample(req_item);
         end
      end
      failures <= fail_count;
      pending  <= expected_summaries.size();
      checked  <= summary_count;
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench top: sample stimulus, result-side stalls and verdict for the run core.

module tb;
   import lvpr_pkg::*;

   localparam int MAX_SAMPLES          = 65536;
   localparam int RANDOM_ITEMS         = 1650;
   localparam int MIN_RANDOM_SEQUENCES = 48;

   // how a random sequence is shaped
   typedef enum int {
      SHAPE_RUNS,
      SHAPE_UNIFORM,
      SHAPE_EXTREMES,
      SHAPE_NARROW
   } shape_type;

   // result-side stall behavior, switched to a random mode when its countdown ends
   typedef enum int {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_HOLD
   } rx_mode_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int failures;
   int pending;
   int checked;

   int burst_left     = 0;
   int items_sent     = 0;
   int sequences_sent = 0;
   int random_items   = 0;
   int random_seqs    = 0;
   int directed_values[$];

   rx_mode_type rx_mode   = RX_OPEN;
   int          mode_left = 0;
   int          hold_left = 0;

   longest_valley_and_peak_run_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   lvpr_checker #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) summary_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .failures  (failures),
      .pending   (pending),
      .checked   (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well past the slowest legal run: about 1700 items, each at
   // its longest gap and behind long result stalls, several times over.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Result-side stalls. Modes cover no stall, sparse and dense random
   // stalls, and long held stretches, so a result can land in any of them.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_mode   <= RX_OPEN;
         mode_left <= 40;
         hold_left <= 0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN: begin
               rsp_stall <= 1'b0;
            end
            RX_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 9) < 3);
            end
            RX_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 9) < 7);
            end
            default: begin
               if (hold_left == 0) begin
                  hold_left <= $urandom_range(1, 12);
                  rsp_stall <= ~rsp_stall;
               end else begin
                  hold_left <= hold_left - 1;
               end
            end
         endcase
      end
   end

   // Offer one item and return at the edge where it is taken. Valid only
   // drops at the start of a gap, and the payload holds while stalled.
   task automatic send_item(input req_item_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
      if (item.last) sequences_sent++;
   endtask

   // Stop sending until every summary has come back, then a short hold-off
   // so the core has settled. pending is registered, hence the first wait.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_directed();
      req_item_type item;
      for (int k = 0; k < directed_values.size(); k++) begin
         item.sample = SAMPLE_BITS'(directed_values[k]);
         item.last   = (k == directed_values.size() - 1);
         send_item(item);
      end
   endtask

   // Random sequence, mostly short. Run-shaped content alternates falling
   // and rising segments so valleys and peaks form; the other shapes give
   // full-range noise, extreme values and dense equal pairs.
   task automatic send_random_sequence();
      req_item_type item;
      shape_type    shape;
      int           len;
      int           pick;
      int           cur;
      int           dir;
      int           stride;
      int           seg_left;
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 16);
      else if (pick < 19) len = $urandom_range(17, 80);
      else len = $urandom_range(81, 300);
      pick = $urandom_range(0, 9);
      if (pick < 6) shape = SHAPE_RUNS;
      else if (pick == 6) shape = SHAPE_UNIFORM;
      else if (pick == 7) shape = SHAPE_EXTREMES;
      else shape = SHAPE_NARROW;
      cur      = int'($urandom_range(0, 65535)) - 32768;
      dir      = $urandom_range(0, 1) ? 1 : -1;
      stride   = 1;
      seg_left = 0;
      for (int k = 0; k < len; k++) begin
         case (shape)
            SHAPE_RUNS: begin
               if (k != 0) begin
                  if (seg_left == 0) begin
                     seg_left = $urandom_range(1, 8);
                     stride   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                            : $urandom_range(1, 4);
                     if ($urandom_range(0, 11) == 0) dir = 0;
                     else if (dir == 0 || $urandom_range(0, 4) == 0)
                        dir = $urandom_range(0, 1) ? 1 : -1;
                     else dir = -dir;
                  end
                  seg_left--;
                  cur = cur + dir * stride;
                  if (cur > 32767) cur = 32767;
                  if (cur < -32768) cur = -32768;
               end
            end
            SHAPE_UNIFORM: begin
               cur = int'($urandom_range(0, 65535)) - 32768;
            end
            SHAPE_EXTREMES: begin
               case ($urandom_range(0, 4))
                  0: cur = -32768;
                  1: cur = 32767;
                  2: cur = 0;
                  3: cur = -1;
                  default: cur = 1;
               endcase
            end
            default: begin
               cur = int'($urandom_range(0, 6)) - 3;
            end
         endcase
         item.sample = SAMPLE_BITS'(cur);
         item.last   = (k == len - 1);
         send_item(item);
         random_items++;
      end
      random_seqs++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: single and two-sample sequences, an equal pair, full-scale
      // valley and peak, two equal valleys (earlier one kept) around one peak,
      // and an equal pair cutting a fall short before a peak.
      directed_values = {-32768};
      send_directed();
      directed_values = {32767, -32768};
      send_directed();
      directed_values = {7, 7};
      send_directed();
      directed_values = {32767, -32768, 32767};
      send_directed();
      directed_values = {-32768, 32767, -32768};
      send_directed();
      directed_values = {0, -1, 0, -1, 0};
      send_directed();
      directed_values = {5, 3, 1, 1, 4, 6, 2};
      send_directed();
      wait_for_idle();

      // Random sequences; now and then the sender drains the core first.
      while (random_items < RANDOM_ITEMS || random_seqs < MIN_RANDOM_SEQUENCES) begin
         send_random_sequence();
         if ($urandom_range(0, 19) == 0) wait_for_idle();
      end

      wait_for_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d items in %0d sequences, directed edge cases then random shapes.",
               items_sent, sequences_sent);
      $display("Checked %0d summaries, %0d field mismatches.", checked, failures);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* longest_valley_and_peak_run_core.f */
hw/rtl/lvpr_pkg.sv
hw/rtl/lvpr_tracker.sv
hw/rtl/longest_valley_and_peak_run_core.sv
dv/lvpr_checker.sv
dv/tb.sv
